// ----- rtl/core/text_console_writer_top_defines.svh -----
// Assertion macros shared by the text console checker.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Clocked assertion that is ignored while reset is asserted.
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked assertion that is also checked during reset.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tcw_pkg;

	// Item kinds carried in the input tuser field.
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_BACK  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	// Character and attribute constants.
	localparam logic [7:0] NULL_CHAR    = 8'h00;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h02;

	// Field widths of the stream payloads.
	localparam int ACTION_W   = 2;
	localparam int CHAR_W     = 8;
	localparam int CELL_W     = 11;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// Datapath operations issued by the controller.
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_PUT     = 3'd1;
	localparam logic [2:0] OP_NEWLINE = 3'd2;
	localparam logic [2:0] OP_BACK    = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;
	localparam logic [2:0] OP_COPY    = 3'd6;
	localparam logic [2:0] OP_FILL    = 3'd7;

	// Controller to datapath.
	typedef struct packed {
		logic       load_item;
		logic       load_out;
		logic       init_fill;
		logic [2:0] op;
	} tcw_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] action;
		logic       is_null;
		logic       is_newline;
		logic       wrap;
		logic       at_home;
		logic       in_range;
		logic       copy_last;
		logic       fill_last;
	} tcw_status_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// Controller of the text console writer: sequences each item, the store sweeps
// and the output register. Depends on tcw_pkg.
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tcw_pkg::tcw_status_t st,
	output tcw_pkg::tcw_cmd_t   cmd
);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_COPY = 3'd3;
	localparam logic [2:0] S_FILL = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.op        = tcw_pkg::OP_FILL;
				cmd.init_fill = 1'b1;
				if (st.fill_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				case (st.action)
					tcw_pkg::ACT_PUT: begin
						if (st.is_null) begin
							cmd.op = tcw_pkg::OP_NONE;
						end else begin
							cmd.op = st.is_newline ? tcw_pkg::OP_NEWLINE : tcw_pkg::OP_PUT;
							if (st.wrap) begin
								state_d = S_COPY;
							end
						end
					end
					tcw_pkg::ACT_BACK: begin
						cmd.op = st.at_home ? tcw_pkg::OP_NONE : tcw_pkg::OP_BACK;
					end
					tcw_pkg::ACT_CLEAR: begin
						cmd.op  = tcw_pkg::OP_CLEAR;
						state_d = S_FILL;
					end
					tcw_pkg::ACT_READ: begin
						cmd.op = st.in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NONE;
					end
					default: begin
						cmd.op = tcw_pkg::OP_NONE;
					end
				endcase
			end
			S_COPY: begin
				cmd.op = tcw_pkg::OP_COPY;
				if (st.copy_last) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.op = tcw_pkg::OP_FILL;
				if (st.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// Hand the result over and take the next item in the same cycle.
				if (out_free) begin
					cmd.load_out = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.load_item = 1'b1;
						state_d       = S_EXEC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// Datapath of the text console writer: item registers, cursor, sweep counter,
// the screen store and the result register. Depends on tcw_pkg and tcw_ram.
module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcw_pkg::tcw_cmd_t            cmd,
	output tcw_pkg::tcw_status_t         st,
	input  logic [tcw_pkg::ACTION_W-1:0] in_action,
	input  logic [tcw_pkg::CHAR_W-1:0]   in_char,
	input  logic [tcw_pkg::CELL_W-1:0]   in_cell,
	input  logic                         cfg_we,
	input  logic [tcw_pkg::CHAR_W-1:0]   cfg_color,
	output logic [tcw_pkg::CELL_W-1:0]   out_cursor,
	output logic [tcw_pkg::CHAR_W-1:0]   out_char,
	output logic [tcw_pkg::CHAR_W-1:0]   out_attr,
	output logic                         out_scrolled
);

	localparam int TOTAL    = COLUMNS * ROWS;
	localparam int LAST_ROW = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W   = $clog2(TOTAL);
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int CELL_BITS = 2 * tcw_pkg::CHAR_W;

	localparam logic [ADDR_W-1:0] TOTAL_M1 = ADDR_W'(TOTAL - 1);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(LAST_ROW);
	localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(COLUMNS - 1);
	localparam logic [15:0]       TOTAL_W  = 16'(TOTAL);

	logic [tcw_pkg::CHAR_W-1:0]   color_q;
	logic [tcw_pkg::ACTION_W-1:0] action_q;
	logic [tcw_pkg::CHAR_W-1:0]   code_q;
	logic [tcw_pkg::CELL_W-1:0]   idx_q;
	logic [ADDR_W-1:0]            cursor_q;
	logic [COL_W-1:0]             col_q;
	logic [ADDR_W-1:0]            sw_q;
	logic                         scroll_q;
	logic                         rd_sel_q;
	logic [tcw_pkg::CELL_W-1:0]   out_cursor_q;
	logic [tcw_pkg::CHAR_W-1:0]   out_char_q;
	logic [tcw_pkg::CHAR_W-1:0]   out_attr_q;
	logic                         out_scrolled_q;

	logic                         we;
	logic [ADDR_W-1:0]            waddr;
	logic [CELL_BITS-1:0]         wdata;
	logic                         re;
	logic [ADDR_W-1:0]            raddr;
	logic [CELL_BITS-1:0]         rdata;
	logic [tcw_pkg::CHAR_W-1:0]   fill_color;

	// Status toward the controller.
	always_comb begin
		st.action     = action_q;
		st.is_null    = (code_q == tcw_pkg::NULL_CHAR);
		st.is_newline = (code_q == tcw_pkg::NEWLINE_CHAR);
		st.wrap       = st.is_newline ? (cursor_q >= LAST_A) : (cursor_q == TOTAL_M1);
		st.at_home    = (cursor_q == '0);
		st.in_range   = ({5'd0, idx_q} < TOTAL_W);
		st.copy_last  = (sw_q == LAST_A);
		st.fill_last  = (sw_q == TOTAL_M1);
	end

	assign fill_color = cmd.init_fill ? tcw_pkg::RESET_COLOR : color_q;

	// Store port steering. A cell holds the character in the low byte.
	always_comb begin
		we    = 1'b0;
		waddr = cursor_q;
		wdata = {color_q, code_q};
		re    = 1'b0;
		raddr = sw_q + COLS_A;
		case (cmd.op)
			tcw_pkg::OP_PUT: begin
				we = 1'b1;
			end
			tcw_pkg::OP_BACK: begin
				we    = 1'b1;
				waddr = cursor_q - 1'b1;
				wdata = {color_q, tcw_pkg::BLANK_CHAR};
			end
			tcw_pkg::OP_READ: begin
				re    = 1'b1;
				raddr = ADDR_W'(idx_q);
			end
			tcw_pkg::OP_COPY: begin
				// Read one row ahead while writing back the previous read.
				re    = (sw_q != LAST_A);
				we    = (sw_q != '0);
				waddr = sw_q - 1'b1;
				wdata = rdata;
			end
			tcw_pkg::OP_FILL: begin
				we    = 1'b1;
				waddr = sw_q;
				wdata = {fill_color, tcw_pkg::BLANK_CHAR};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_BITS),
		.DEPTH(TOTAL)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Text color register, written through the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcw_pkg::RESET_COLOR;
		end else if (cfg_we) begin
			color_q <= cfg_color;
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_action;
			code_q   <= in_char;
			idx_q    <= in_cell;
		end
	end

	// Cursor, column, sweep counter and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
			sw_q     <= '0;
			scroll_q <= 1'b0;
			rd_sel_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				scroll_q <= 1'b0;
				rd_sel_q <= 1'b0;
			end
			case (cmd.op)
				tcw_pkg::OP_PUT: begin
					if (st.wrap) begin
						cursor_q <= LAST_A;
						col_q    <= '0;
						scroll_q <= 1'b1;
					end else begin
						cursor_q <= cursor_q + 1'b1;
						col_q    <= (col_q == COL_MAX) ? '0 : col_q + 1'b1;
					end
				end
				tcw_pkg::OP_NEWLINE: begin
					col_q <= '0;
					if (st.wrap) begin
						cursor_q <= LAST_A;
						scroll_q <= 1'b1;
					end else begin
						cursor_q <= cursor_q + COLS_A - ADDR_W'(col_q);
					end
				end
				tcw_pkg::OP_BACK: begin
					cursor_q <= cursor_q - 1'b1;
					col_q    <= (col_q == '0) ? COL_MAX : col_q - 1'b1;
				end
				tcw_pkg::OP_CLEAR: begin
					cursor_q <= '0;
					col_q    <= '0;
				end
				tcw_pkg::OP_READ: begin
					rd_sel_q <= 1'b1;
				end
				tcw_pkg::OP_COPY: begin
					// Park on the last row start; the fill continues from there.
					if (!st.copy_last) begin
						sw_q <= sw_q + 1'b1;
					end
				end
				tcw_pkg::OP_FILL: begin
					sw_q <= st.fill_last ? '0 : sw_q + 1'b1;
				end
				default: begin
					sw_q <= sw_q;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_cursor_q   <= tcw_pkg::CELL_W'(cursor_q);
			out_char_q     <= rd_sel_q ? rdata[tcw_pkg::CHAR_W-1:0] : '0;
			out_attr_q     <= rd_sel_q ? rdata[CELL_BITS-1:tcw_pkg::CHAR_W] : '0;
			out_scrolled_q <= scroll_q;
		end
	end

	assign out_cursor   = out_cursor_q;
	assign out_char     = out_char_q;
	assign out_attr     = out_attr_q;
	assign out_scrolled = out_scrolled_q;

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// Top level of the text console writer: stream ports, payload packing and the
// controller and datapath. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage: each input beat carries one item: tuser is the action (put character,
// backspace, clear screen, read cell), tdata the character and the cell index.
// Every item gives exactly one output beat with the cursor cell, the character
// and attribute read (zero unless a read) and a scroll flag.
// The cfg channel writes the text color attribute; it is always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// An accepted item passes the execute state, any sweep, and the done state, where
// its result is loaded into the output register and the next item may be taken
// once that register is free; no new item is taken before. A scroll copies the
// screen up through the store's single read and write port, then blanks the
// bottom row. A clear blanks the store one cell per cycle.
// Reset: cursor goes home and the color returns to 0x02; a clearing pass then
// fills the store with blanks while s_axis_tready is low. When the receiver
// stalls, the result is held in the output register and one further item may
// be accepted and worked on before s_axis_tready drops.
module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] char_code, [18:8] cell_index, [23:19] zero
	input  logic [tcw_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] action
	input  logic [tcw_pkg::ACTION_W-1:0]      s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [10:0] cursor_cell, [18:11] read_char, [26:19] read_attr, [27] scrolled,
	// [31:28] zero
	output logic [tcw_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcw_pkg::CHAR_W-1:0]        cfg_data
);

	tcw_pkg::tcw_cmd_t           cmd;
	tcw_pkg::tcw_status_t        st;
	logic [tcw_pkg::CELL_W-1:0]  out_cursor;
	logic [tcw_pkg::CHAR_W-1:0]  out_char;
	logic [tcw_pkg::CHAR_W-1:0]  out_attr;
	logic                        out_scrolled;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tcw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_action   (s_axis_tuser),
		.in_char     (s_axis_tdata[7:0]),
		.in_cell     (s_axis_tdata[18:8]),
		.cfg_we      (cfg_valid),
		.cfg_color   (cfg_data),
		.out_cursor  (out_cursor),
		.out_char    (out_char),
		.out_attr    (out_attr),
		.out_scrolled(out_scrolled)
	);

	// Result beat packing, first field in the lowest bits.
	assign m_axis_tdata = {4'd0, out_scrolled, out_attr, out_char, out_cursor};

endmodule

// ----- rtl/core/tcw_checker.sv -----
// Port-level checker of the text console writer, bound to the top level.
// Depends on text_console_writer_top_defines.svh and text_console_writer_top.
`include "text_console_writer_top_defines.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	localparam logic [10:0] LAST_CELL = 11'((ROWS - 1) * COLUMNS);

	logic       in_beat;
	logic       out_beat;
	logic [2:0] pend_q;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;

	// Items accepted whose result beat has not gone out yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'd0, in_beat} - {2'd0, out_beat};
		end
	end

	`TCW_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped or changed while stalled")
	`TCW_ASSERT(a_pend_bound, pend_q <= 3'd2, "more than two items in flight")
	`TCW_ASSERT(a_no_orphan, m_axis_tvalid |-> pend_q != 3'd0, "result beat without an accepted item")
	`TCW_ASSERT(a_scroll_cursor, m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[10:0] == LAST_CELL, "scroll did not leave the cursor at the bottom row start")
	`TCW_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_axis_tvalid, "result beat during reset")

endmodule

bind text_console_writer_top tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (.*);
